@@ hw/rtl/complex_arithmetic_unit_assert.svh @@
// ----------------------------------------------------------------------------
// complex arithmetic unit assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// clocked property, off while reset is asserted
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked property, also checked during reset
`define CAU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// widths, operation codes and shared types of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int LinW  = DATA_WIDTH + 1;              // sum or difference
  localparam int ProdW = 2 * DATA_WIDTH;              // one product
  localparam int SumW  = ProdW + 1;                   // sum of two products
  localparam int CubW  = ProdW + 2;                   // a^2 - 3b^2 style terms
  localparam int SatW  = CubW;                        // saturation input
  localparam int CubPW = DATA_WIDTH + CubW;           // full cube term
  localparam int QuoW  = DATA_WIDTH;                  // quotient bits
  localparam int DvsW  = ProdW + 1;                   // doubled divisor
  localparam int NumW  = ProdW + FRAC_BITS + 1;       // doubled dividend plus divisor

  localparam logic [2:0] OpAdd = 3'd0;
  localparam logic [2:0] OpSub = 3'd1;
  localparam logic [2:0] OpMul = 3'd2;
  localparam logic [2:0] OpDiv = 3'd3;
  localparam logic [2:0] OpSqr = 3'd4;
  localparam logic [2:0] OpCub = 3'd5;
  localparam logic [2:0] OpNeg = 3'd6;
  localparam logic [2:0] OpRcp = 3'd7;

  localparam logic [DATA_WIDTH-1:0] ResMax = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] ResMin = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // one lane of the restoring divider
  typedef struct packed {
    logic [DvsW-1:0] rem;
    logic [QuoW-1:0] nlow;
    logic [QuoW-1:0] quo;
    logic [DvsW-1:0] dvs;
  } div_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] re;
    logic [DATA_WIDTH-1:0] im;
    logic                  sat;
  } res_t;

  // what travels beside the divider lanes
  typedef struct packed {
    res_t       res;
    logic [1:0] neg;
    logic [1:0] big;
    logic       dz;
    logic       is_div;
  } side_t;

endpackage

@@ hw/rtl/cau_req_if.sv @@
// ----------------------------------------------------------------------------
// cau_req_if
// operand channel: opcode and two complex operands
// ----------------------------------------------------------------------------
interface cau_req_if;
  import cau_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [2:0]                   req_type;
  logic signed [DATA_WIDTH-1:0] a_re;
  logic signed [DATA_WIDTH-1:0] a_im;
  logic signed [DATA_WIDTH-1:0] b_re;
  logic signed [DATA_WIDTH-1:0] b_im;

  modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

@@ hw/rtl/cau_rsp_if.sv @@
// ----------------------------------------------------------------------------
// cau_rsp_if
// result channel: complex result and flags
// ----------------------------------------------------------------------------
interface cau_rsp_if;
  import cau_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_re;
  logic signed [DATA_WIDTH-1:0] res_im;
  logic                         saturated;
  logic                         div_by_zero;

  modport source (output valid, res_re, res_im, saturated, div_by_zero, input ready);
  modport sink (input valid, res_re, res_im, saturated, div_by_zero, output ready);
endinterface

@@ hw/rtl/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// pipelined complex add, subtract, multiply, divide, square, cube, negate
// and reciprocal on signed Q16.16 operands
// ----------------------------------------------------------------------------
// Every operation goes through the same 38-stage pipeline, and one item can be
// taken every cycle unless a result waits unaccepted at the output.
// The length is set by the 32-step restoring divider used by divide and
// reciprocal (one quotient bit per stage); five stages ahead of it form the
// products, the cube terms and the rounding, one output register follows it.
// Results are rounded to nearest, ties away from zero, and each part saturates
// on its own. The whole pipeline holds while a result waits at the output.
module complex_arithmetic_unit (
  input logic      clk_i,
  input logic      rst_ni,
  cau_req_if.sink  req_i,
  cau_rsp_if.source rsp_o
);
  import cau_pkg::*;

  localparam logic signed [SumW-1:0]  MulHalf = SumW'(1) << (FRAC_BITS - 1);
  localparam logic signed [CubPW-1:0] CubHalf = CubPW'(1) << (2 * FRAC_BITS - 1);

  function automatic logic [DATA_WIDTH:0] sat_fn(input logic [SatW-1:0] x);
    logic [SatW-DATA_WIDTH:0] hdr;
    logic [DATA_WIDTH:0]      r;
    hdr = x[SatW-1:DATA_WIDTH-1];
    if ((&hdr) || !(|hdr)) begin
      r = {1'b0, x[DATA_WIDTH-1:0]};
    end else if (x[SatW-1]) begin
      r = {1'b1, ResMin};
    end else begin
      r = {1'b1, ResMax};
    end
    return r;
  endfunction

  logic en;
  logic rsp_vld_q;

  assign en          = !rsp_vld_q || rsp_o.ready;
  assign req_i.ready = en;

  // ---- stage a: products ----
  logic                         use_a;
  logic signed [DATA_WIDTH-1:0] br_in, bi_in;
  logic signed [LinW-1:0]       lre_d, lim_d;

  logic                         vld_a_q;
  logic [2:0]                   op_a_q;
  logic signed [DATA_WIDTH-1:0] ar_a_q, ai_a_q;
  logic signed [LinW-1:0]       lre_a_q, lim_a_q;
  logic signed [ProdW-1:0]      prr_a_q, pii_a_q, pri_a_q, pir_a_q, pbr_a_q, pbi_a_q;

  always_comb begin
    use_a = (req_i.req_type == OpSqr) || (req_i.req_type == OpCub) ||
            (req_i.req_type == OpRcp);
    br_in = use_a ? req_i.a_re : req_i.b_re;
    bi_in = use_a ? req_i.a_im : req_i.b_im;
    case (req_i.req_type)
      OpAdd: begin
        lre_d = LinW'(req_i.a_re) + LinW'(req_i.b_re);
        lim_d = LinW'(req_i.a_im) + LinW'(req_i.b_im);
      end
      OpSub: begin
        lre_d = LinW'(req_i.a_re) - LinW'(req_i.b_re);
        lim_d = LinW'(req_i.a_im) - LinW'(req_i.b_im);
      end
      OpNeg: begin
        lre_d = -LinW'(req_i.a_re);
        lim_d = -LinW'(req_i.a_im);
      end
      default: begin
        lre_d = '0;
        lim_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (en) begin
      vld_a_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_a_q  <= req_i.req_type;
      ar_a_q  <= req_i.a_re;
      ai_a_q  <= req_i.a_im;
      lre_a_q <= lre_d;
      lim_a_q <= lim_d;
      prr_a_q <= req_i.a_re * br_in;
      pii_a_q <= req_i.a_im * bi_in;
      pri_a_q <= req_i.a_re * bi_in;
      pir_a_q <= req_i.a_im * br_in;
      pbr_a_q <= br_in * br_in;
      pbi_a_q <= bi_in * bi_in;
    end
  end

  // ---- stage b: sums of products ----
  logic signed [SumW-1:0] nre_b_d, nim_b_d;

  logic                         vld_b_q;
  logic [2:0]                   op_b_q;
  logic signed [DATA_WIDTH-1:0] ar_b_q, ai_b_q;
  logic signed [LinW-1:0]       lre_b_q, lim_b_q;
  logic signed [SumW-1:0]       mre_b_q, mim_b_q, nre_b_q, nim_b_q;
  logic signed [CubW-1:0]       cre_b_q, cim_b_q;
  logic [ProdW-1:0]             dsq_b_q;

  always_comb begin
    if (op_a_q == OpRcp) begin
      nre_b_d = SumW'(ar_a_q);
      nim_b_d = -SumW'(ai_a_q);
    end else begin
      nre_b_d = SumW'(prr_a_q) + SumW'(pii_a_q);
      nim_b_d = SumW'(pir_a_q) - SumW'(pri_a_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else if (en) begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_b_q  <= op_a_q;
      ar_b_q  <= ar_a_q;
      ai_b_q  <= ai_a_q;
      lre_b_q <= lre_a_q;
      lim_b_q <= lim_a_q;
      mre_b_q <= SumW'(prr_a_q) - SumW'(pii_a_q);
      mim_b_q <= SumW'(pri_a_q) + SumW'(pir_a_q);
      nre_b_q <= nre_b_d;
      nim_b_q <= nim_b_d;
      dsq_b_q <= $unsigned(pbr_a_q) + $unsigned(pbi_a_q);
      // cube: a_re^2 - 3 a_im^2 and 3 a_re^2 - a_im^2
      cre_b_q <= CubW'(prr_a_q) - (CubW'(pii_a_q) + (CubW'(pii_a_q) <<< 1));
      cim_b_q <= (CubW'(prr_a_q) <<< 1) + CubW'(prr_a_q) - CubW'(pii_a_q);
    end
  end

  // ---- stage c: rounding of products, cube products, divider operands ----
  logic signed [SumW-1:0] mre_rnd, mim_rnd;
  logic [SumW-1:0]        abs_re, abs_im;
  logic [NumW-1:0]        m_re, m_im;
  logic                   rcp_b;

  logic                         vld_c_q;
  logic [2:0]                   op_c_q;
  logic signed [LinW-1:0]       lre_c_q, lim_c_q;
  logic [DATA_WIDTH:0]          mre_c_q, mim_c_q;
  logic signed [SumW-1:0]       crl_c_q, cil_c_q;
  logic signed [CubW-1:0]       crh_c_q, cih_c_q;
  logic [NumW-1:0]              nn_re_c_q, nn_im_c_q;
  logic [1:0]                   neg_c_q;
  logic [DvsW-1:0]              dvs_c_q;
  logic                         dz_c_q;
  logic                         is_div_c_q;

  always_comb begin
    mre_rnd = (mre_b_q + (mre_b_q[SumW-1] ? MulHalf - SumW'(1) : MulHalf)) >>> FRAC_BITS;
    mim_rnd = (mim_b_q + (mim_b_q[SumW-1] ? MulHalf - SumW'(1) : MulHalf)) >>> FRAC_BITS;
    abs_re  = nre_b_q[SumW-1] ? -nre_b_q : nre_b_q;
    abs_im  = nim_b_q[SumW-1] ? -nim_b_q : nim_b_q;
    rcp_b   = op_b_q == OpRcp;
    m_re    = rcp_b ? (NumW'(abs_re[ProdW-1:0]) << (2 * FRAC_BITS + 1))
                    : (NumW'(abs_re[ProdW-1:0]) << (FRAC_BITS + 1));
    m_im    = rcp_b ? (NumW'(abs_im[ProdW-1:0]) << (2 * FRAC_BITS + 1))
                    : (NumW'(abs_im[ProdW-1:0]) << (FRAC_BITS + 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
    end else if (en) begin
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_c_q     <= op_b_q;
      lre_c_q    <= lre_b_q;
      lim_c_q    <= lim_b_q;
      mre_c_q    <= sat_fn(SatW'(mre_rnd));
      mim_c_q    <= sat_fn(SatW'(mim_rnd));
      crl_c_q    <= ar_b_q * $signed({1'b0, cre_b_q[DATA_WIDTH-1:0]});
      crh_c_q    <= ar_b_q * $signed(cre_b_q[CubW-1:DATA_WIDTH]);
      cil_c_q    <= ai_b_q * $signed({1'b0, cim_b_q[DATA_WIDTH-1:0]});
      cih_c_q    <= ai_b_q * $signed(cim_b_q[CubW-1:DATA_WIDTH]);
      // 2|n| + d over 2d gives the quotient rounded half away from zero
      nn_re_c_q  <= m_re + NumW'(dsq_b_q);
      nn_im_c_q  <= m_im + NumW'(dsq_b_q);
      neg_c_q    <= {nim_b_q[SumW-1], nre_b_q[SumW-1]};
      dvs_c_q    <= {dsq_b_q, 1'b0};
      dz_c_q     <= dsq_b_q == '0;
      is_div_c_q <= (op_b_q == OpDiv) || (op_b_q == OpRcp);
    end
  end

  // ---- stage d: cube sums, divider start, linear results ----
  logic [DATA_WIDTH:0] lre_sat, lim_sat;
  res_t                res_d_d;
  div_t                dre_d, dim_d;

  logic                    vld_d_q;
  logic [2:0]              op_d_q;
  logic signed [CubPW-1:0] cre_d_q, cim_d_q;
  res_t                    res_d_q;
  div_t                    dre_d_q, dim_d_q;
  logic [1:0]              neg_d_q, big_d_q;
  logic                    dz_d_q, is_div_d_q;

  always_comb begin
    lre_sat = sat_fn(SatW'(lre_c_q));
    lim_sat = sat_fn(SatW'(lim_c_q));
    case (op_c_q)
      OpAdd, OpSub, OpNeg: begin
        res_d_d = {lre_sat[DATA_WIDTH-1:0], lim_sat[DATA_WIDTH-1:0],
                   lre_sat[DATA_WIDTH] | lim_sat[DATA_WIDTH]};
      end
      default: begin
        res_d_d = {mre_c_q[DATA_WIDTH-1:0], mim_c_q[DATA_WIDTH-1:0],
                   mre_c_q[DATA_WIDTH] | mim_c_q[DATA_WIDTH]};
      end
    endcase
    dre_d.rem  = DvsW'(nn_re_c_q[NumW-1:QuoW]);
    dre_d.nlow = nn_re_c_q[QuoW-1:0];
    dre_d.quo  = '0;
    dre_d.dvs  = dvs_c_q;
    dim_d.rem  = DvsW'(nn_im_c_q[NumW-1:QuoW]);
    dim_d.nlow = nn_im_c_q[QuoW-1:0];
    dim_d.quo  = '0;
    dim_d.dvs  = dvs_c_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q <= 1'b0;
    end else if (en) begin
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_d_q     <= op_c_q;
      cre_d_q    <= (CubPW'(crh_c_q) <<< DATA_WIDTH) + CubPW'(crl_c_q);
      cim_d_q    <= (CubPW'(cih_c_q) <<< DATA_WIDTH) + CubPW'(cil_c_q);
      res_d_q    <= res_d_d;
      dre_d_q    <= dre_d;
      dim_d_q    <= dim_d;
      neg_d_q    <= neg_c_q;
      // quotient of 2^32 or more always clips
      big_d_q    <= {DvsW'(nn_im_c_q[NumW-1:QuoW]) >= dvs_c_q,
                     DvsW'(nn_re_c_q[NumW-1:QuoW]) >= dvs_c_q};
      dz_d_q     <= dz_c_q;
      is_div_d_q <= is_div_c_q;
    end
  end

  // ---- stage e: cube rounding ----
  logic signed [CubPW-1:0] cre_rnd, cim_rnd;
  logic [DATA_WIDTH:0]     cre_sat, cim_sat;
  side_t                   side_e_d;

  logic  vld_e_q;
  side_t side_e_q;
  div_t  dre_e_q, dim_e_q;

  always_comb begin
    cre_rnd = (cre_d_q + (cre_d_q[CubPW-1] ? CubHalf - CubPW'(1) : CubHalf))
              >>> (2 * FRAC_BITS);
    cim_rnd = (cim_d_q + (cim_d_q[CubPW-1] ? CubHalf - CubPW'(1) : CubHalf))
              >>> (2 * FRAC_BITS);
    cre_sat = sat_fn(SatW'(cre_rnd));
    cim_sat = sat_fn(SatW'(cim_rnd));
    side_e_d.res    = res_d_q;
    side_e_d.neg    = neg_d_q;
    side_e_d.big    = big_d_q;
    side_e_d.dz     = dz_d_q;
    side_e_d.is_div = is_div_d_q;
    if (op_d_q == OpCub) begin
      side_e_d.res = {cre_sat[DATA_WIDTH-1:0], cim_sat[DATA_WIDTH-1:0],
                      cre_sat[DATA_WIDTH] | cim_sat[DATA_WIDTH]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_e_q <= 1'b0;
    end else if (en) begin
      vld_e_q <= vld_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_e_q <= side_e_d;
      dre_e_q  <= dre_d_q;
      dim_e_q  <= dim_d_q;
    end
  end

  // ---- divider stages ----
  logic  vld_w  [QuoW+1];
  side_t side_w [QuoW+1];
  div_t  dre_w  [QuoW+1];
  div_t  dim_w  [QuoW+1];
  logic  vld_s_q  [QuoW];
  side_t side_s_q [QuoW];

  assign vld_w[0]  = vld_e_q;
  assign side_w[0] = side_e_q;
  assign dre_w[0]  = dre_e_q;
  assign dim_w[0]  = dim_e_q;

  for (genvar k = 0; k < QuoW; k++) begin : g_div
    cau_div_stage u_re (
      .clk_i (clk_i),
      .en_i  (en),
      .div_i (dre_w[k]),
      .div_o (dre_w[k+1])
    );
    cau_div_stage u_im (
      .clk_i (clk_i),
      .en_i  (en),
      .div_i (dim_w[k]),
      .div_o (dim_w[k+1])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s_q[k] <= 1'b0;
      end else if (en) begin
        vld_s_q[k] <= vld_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        side_s_q[k] <= side_w[k];
      end
    end

    assign vld_w[k+1]  = vld_s_q[k];
    assign side_w[k+1] = side_s_q[k];
  end

  // ---- output register ----
  side_t               side_f;
  logic [QuoW-1:0]     q_re, q_im;
  logic [DATA_WIDTH:0] qre_sat, qim_sat;
  res_t                res_f;
  logic                dz_f;

  res_t rsp_res_q;
  logic rsp_dz_q;

  always_comb begin
    side_f = side_w[QuoW];
    q_re   = dre_w[QuoW].quo;
    q_im   = dim_w[QuoW].quo;
    if (side_f.big[0]) begin
      qre_sat = {1'b1, side_f.neg[0] ? ResMin : ResMax};
    end else begin
      qre_sat = sat_fn(side_f.neg[0] ? -SatW'(q_re) : SatW'(q_re));
    end
    if (side_f.big[1]) begin
      qim_sat = {1'b1, side_f.neg[1] ? ResMin : ResMax};
    end else begin
      qim_sat = sat_fn(side_f.neg[1] ? -SatW'(q_im) : SatW'(q_im));
    end
    res_f = side_f.res;
    dz_f  = 1'b0;
    if (side_f.is_div) begin
      if (side_f.dz) begin
        res_f = '0;
        dz_f  = 1'b1;
      end else begin
        res_f = {qre_sat[DATA_WIDTH-1:0], qim_sat[DATA_WIDTH-1:0],
                 qre_sat[DATA_WIDTH] | qim_sat[DATA_WIDTH]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (en) begin
      rsp_vld_q <= vld_w[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_res_q <= res_f;
      rsp_dz_q  <= dz_f;
    end
  end

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.res_re      = rsp_res_q.re;
  assign rsp_o.res_im      = rsp_res_q.im;
  assign rsp_o.saturated   = rsp_res_q.sat;
  assign rsp_o.div_by_zero = rsp_dz_q;

endmodule

@@ hw/rtl/cau_div_stage.sv @@
// ----------------------------------------------------------------------------
// cau_div_stage
// one registered step of the restoring divider, one quotient bit
// ----------------------------------------------------------------------------
module cau_div_stage (
  input  logic          clk_i,
  input  logic          en_i,
  input  cau_pkg::div_t div_i,
  output cau_pkg::div_t div_o
);
  import cau_pkg::*;

  logic [DvsW:0] trial;
  logic [DvsW:0] diff;
  logic          fit;
  div_t          div_d;
  div_t          div_q;

  always_comb begin
    trial       = {div_i.rem, div_i.nlow[QuoW-1]};
    diff        = trial - {1'b0, div_i.dvs};
    fit         = trial >= {1'b0, div_i.dvs};
    div_d.rem   = fit ? diff[DvsW-1:0] : trial[DvsW-1:0];
    div_d.nlow  = {div_i.nlow[QuoW-2:0], 1'b0};
    div_d.quo   = {div_i.quo[QuoW-2:0], fit};
    div_d.dvs   = div_i.dvs;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

@@ hw/rtl/cau_checker.sv @@
// ----------------------------------------------------------------------------
// cau_checker
// port-level checks of the complex arithmetic unit, bound to the top level
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_assert.svh"

module cau_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                req_ready_i,
  input logic                                rsp_valid_i,
  input logic                                rsp_ready_i,
  input logic [cau_pkg::DATA_WIDTH-1:0]      res_re_i,
  input logic [cau_pkg::DATA_WIDTH-1:0]      res_im_i,
  input logic                                saturated_i,
  input logic                                div_by_zero_i
);
  import cau_pkg::*;

  // a waiting result stays until taken
  `CAU_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "result lost under stall")

  // with nothing waiting at the output the input side never stalls
  `CAU_ASSERT(a_ready_free, !rsp_valid_i |-> req_ready_i, "input stalled with empty output")

  `CAU_ASSERT(a_dz_zero, rsp_valid_i && div_by_zero_i |-> res_re_i == '0 && res_im_i == '0 && !saturated_i, "divide by zero result not cleared")

  // a clipped item has at least one part on a rail
  `CAU_ASSERT(a_sat_rail, rsp_valid_i && saturated_i |-> res_re_i == ResMax || res_re_i == ResMin || res_im_i == ResMax || res_im_i == ResMin, "saturated without a clipped part")

  // an edge seen in reset has cleared the output by the next edge
  `CAU_ASSERT_RST(a_rst_empty, !rst_ni |=> !rsp_valid_i, "output valid after reset")

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .res_re_i      (rsp_o.res_re),
  .res_im_i      (rsp_o.res_im),
  .saturated_i   (rsp_o.saturated),
  .div_by_zero_i (rsp_o.div_by_zero)
);
